// ----- rtl/core/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared assertion macros, clocked on clk and disabled during reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication or plain property checked on every rising clk edge
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition that must never be seen on a rising clk edge
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ----- rtl/core/prm_pkg.sv -----
// ----------------------------------------------------------------------------
// prm_pkg
// shared types and constants of the packet rule matcher
// ----------------------------------------------------------------------------
package prm_pkg;

    localparam int SLOT_W        = 6;
    localparam int SLOT_SPAN     = 2 ** SLOT_W;
    localparam int ADDR_W        = 64;
    localparam int IPV4_W        = 32;
    localparam int PORT_W        = 16;
    localparam int CMD_W         = 2;
    localparam int RULE_SLOTS_DEF = 64;

    localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CHECK = 2'd2;

    localparam logic [PORT_W-1:0] PORT_ANY = '0;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [SLOT_W-1:0] slot;
        logic [ADDR_W-1:0] addr_high;
        logic [ADDR_W-1:0] addr_low;
        logic [PORT_W-1:0] port_number;
        logic              is_ipv6;
        logic              any_address;
        logic              deny_action;
    } req_t;

    typedef struct packed {
        logic verdict;
        logic any_hit;
    } rsp_t;

    typedef struct packed {
        logic [ADDR_W-1:0] addr_high;
        logic [ADDR_W-1:0] addr_low;
        logic [PORT_W-1:0] port_number;
        logic              is_ipv6;
        logic              any_address;
        logic              deny_action;
    } rule_t;

    typedef struct packed {
        logic clr;
        logic cmp_en;
    } scan_ctl_t;

endpackage

// ----- rtl/core/prm_rule_mem.sv -----
// ----------------------------------------------------------------------------
// prm_rule_mem
// rule storage, one write port and one registered read port
// ----------------------------------------------------------------------------
module prm_rule_mem #(
    parameter int DEPTH = prm_pkg::RULE_SLOTS_DEF,
    parameter int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                 clk,
    input  logic                 wr_en,
    input  logic [IDX_W-1:0]     wr_addr,
    input  prm_pkg::rule_t       wr_data,
    input  logic                 rd_en,
    input  logic [IDX_W-1:0]     rd_addr,
    output prm_pkg::rule_t       rd_data
);

    prm_pkg::rule_t mem [DEPTH];
    prm_pkg::rule_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/core/prm_match_unit.sv -----
// ----------------------------------------------------------------------------
// prm_match_unit
// shared rule compare and hit / deny accumulation, one rule per cycle
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module prm_match_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  prm_pkg::scan_ctl_t  ctl,
    input  prm_pkg::req_t       pkt,
    input  prm_pkg::rule_t      rule,
    input  logic                rule_valid,
    output prm_pkg::rsp_t       acc
);

    logic addr_ok;
    logic port_ok;
    logic rule_hit;
    logic hit_reg;
    logic hit_next;
    logic deny_reg;
    logic deny_next;

    always_comb
    begin
        if (rule.any_address)
        begin
            addr_ok = 1'b1;
        end
        else if (pkt.is_ipv6)
        begin
            addr_ok = (rule.addr_high == pkt.addr_high) && (rule.addr_low == pkt.addr_low);
        end
        else
        begin
            addr_ok = rule.addr_low[prm_pkg::IPV4_W-1:0] == pkt.addr_low[prm_pkg::IPV4_W-1:0];
        end
        port_ok  = (rule.port_number == prm_pkg::PORT_ANY) ||
                   (rule.port_number == pkt.port_number);
        rule_hit = rule_valid && (rule.is_ipv6 == pkt.is_ipv6) && addr_ok && port_ok;
    end

    always_comb
    begin
        hit_next  = hit_reg;
        deny_next = deny_reg;
        if (ctl.clr)
        begin
            hit_next  = 1'b0;
            deny_next = 1'b0;
        end
        else if (ctl.cmp_en && rule_hit)
        begin
            hit_next  = 1'b1;
            deny_next = deny_reg | rule.deny_action;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg  <= 1'b0;
            deny_reg <= 1'b0;
        end
        else
        begin
            hit_reg  <= hit_next;
            deny_reg <= deny_next;
        end
    end

    assign acc.verdict = deny_reg;
    assign acc.any_hit = hit_reg;

    // a deny verdict always comes from a matching rule
    `ASSERT_CLK(a_deny_has_hit, deny_reg |-> hit_reg, "deny set without any hit")
    // clearing wins over accumulation
    `ASSERT_CLK(a_clr_zeroes, ctl.clr |=> (!hit_reg && !deny_reg), "accumulators not cleared")

endmodule

// ----- rtl/core/packet_rule_matcher_unit.sv -----
// ----------------------------------------------------------------------------
// packet_rule_matcher_unit
// firewall rule table with write, clear and packet check transactions
// ----------------------------------------------------------------------------
// usage:
//   request is taken at a rising edge with start high and busy low; busy then
//   stays high until the result has been shown.
//   every transaction gives one result: done is high for exactly one cycle
//   with result valid in that cycle; the receiver cannot stall it.
//   write and clear update the rule slot at the accepting edge; the result
//   (0, 0) follows in the next cycle.
//   a check walks the rule memory one slot per cycle through its single read
//   port over N = min(RULE_SLOTS, 64) slots; each rule read is registered,
//   then compared and accumulated, and ST_DRAIN and ST_RESP show the result;
//   a new request is taken only once busy has fallen after done.
//   slots at or above RULE_SLOTS are ignored by write and clear.
//   reset marks every slot empty at once; rule data needs no clearing pass,
//   since only valid slots take part in a check.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module packet_rule_matcher_unit #(
    parameter int RULE_SLOTS = prm_pkg::RULE_SLOTS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  prm_pkg::req_t  request,
    output logic           busy,
    output logic           done,
    output prm_pkg::rsp_t  result
);

    localparam int DEPTH = (RULE_SLOTS < prm_pkg::SLOT_SPAN) ? RULE_SLOTS : prm_pkg::SLOT_SPAN;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SCAN  = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_RESP  = 4'b1000
    } state_t;

    state_t              state_reg;
    state_t              state_next;
    logic [IDX_W-1:0]    scan_idx_reg;
    logic [IDX_W-1:0]    scan_idx_next;
    logic [DEPTH-1:0]    valid_reg;
    logic [DEPTH-1:0]    valid_next;
    logic                cmp_en_reg;
    logic                cmp_en_next;
    logic                rule_valid_reg;
    prm_pkg::req_t       pkt_reg;
    logic                accept;
    logic                slot_ok;
    logic [IDX_W-1:0]    slot_idx;
    logic                mem_wr_en;
    logic                mem_rd_en;
    prm_pkg::rule_t      wr_rule;
    prm_pkg::rule_t      rd_rule;
    prm_pkg::scan_ctl_t  ctl;

    assign accept   = start && !busy;
    assign slot_ok  = 32'(request.slot) < 32'(RULE_SLOTS);
    assign slot_idx = request.slot[IDX_W-1:0];

    assign mem_wr_en = accept && slot_ok && (request.cmd == prm_pkg::CMD_WRITE);
    assign mem_rd_en = (state_reg == ST_SCAN);

    assign wr_rule.addr_high   = request.addr_high;
    assign wr_rule.addr_low    = request.addr_low;
    assign wr_rule.port_number = request.port_number;
    assign wr_rule.is_ipv6     = request.is_ipv6;
    assign wr_rule.any_address = request.any_address;
    assign wr_rule.deny_action = request.deny_action;

    always_comb
    begin
        state_next    = state_reg;
        scan_idx_next = scan_idx_reg;
        cmp_en_next   = 1'b0;
        valid_next    = valid_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    scan_idx_next = '0;
                    if (request.cmd == prm_pkg::CMD_CHECK)
                    begin
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        state_next = ST_RESP;
                    end
                    if (slot_ok && (request.cmd == prm_pkg::CMD_WRITE))
                    begin
                        valid_next[slot_idx] = 1'b1;
                    end
                    else if (slot_ok && (request.cmd == prm_pkg::CMD_CLEAR))
                    begin
                        valid_next[slot_idx] = 1'b0;
                    end
                end
            end
            ST_SCAN:
            begin
                cmp_en_next   = 1'b1;
                scan_idx_next = scan_idx_reg + 1'b1;
                if (scan_idx_reg == IDX_W'(DEPTH - 1))
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_RESP;
            end
            ST_RESP:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            scan_idx_reg <= '0;
            cmp_en_reg   <= 1'b0;
            valid_reg    <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            scan_idx_reg <= scan_idx_next;
            cmp_en_reg   <= cmp_en_next;
            valid_reg    <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pkt_reg <= request;
        end
        if (mem_rd_en)
        begin
            rule_valid_reg <= valid_reg[scan_idx_reg];
        end
    end

    assign ctl.clr    = accept;
    assign ctl.cmp_en = cmp_en_reg;

    prm_rule_mem #(
        .DEPTH (DEPTH),
        .IDX_W (IDX_W)
    ) u_rule_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (slot_idx),
        .wr_data (wr_rule),
        .rd_en   (mem_rd_en),
        .rd_addr (scan_idx_reg),
        .rd_data (rd_rule)
    );

    prm_match_unit u_match (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .pkt        (pkt_reg),
        .rule       (rd_rule),
        .rule_valid (rule_valid_reg),
        .acc        (result)
    );

    assign busy = (state_reg != ST_IDLE);
    assign done = (state_reg == ST_RESP);

    // an accepted transaction keeps the unit busy
    `ASSERT_CLK(a_accept_busy, accept |=> busy, "not busy after accept")
    // exactly one result, then ready again
    `ASSERT_CLK(a_done_once, done |=> (!done && !busy), "result strobe not single")
    // compares only happen while a check is in flight
    `ASSERT_CLK(a_cmp_in_check, cmp_en_reg |-> (pkt_reg.cmd == prm_pkg::CMD_CHECK),
                "compare outside a check")

endmodule

// ----- sim/tb_packet_rule_matcher_unit.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_packet_rule_matcher_unit
// self-checking bench for the firewall rule table: a directed table covers
// empty-table checks, IPv4 low-word compare, full IPv6 compare, wildcard
// address and port, rule rewrite, clear and the unused command, then a long
// random stream of write, clear, check and unused transactions, with addresses
// mostly drawn from a small pool, is checked against an access-list predictor
// ----------------------------------------------------------------------------
module tb_packet_rule_matcher_unit;
    import prm_pkg::*;

    localparam int CLK_PERIOD = 10;
    localparam int TABLE_DEPTH = RULE_SLOTS_DEF;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int DIRECTED_ROWS = 25;
    localparam int RANDOM_TXNS = 1850;
    localparam int POOL_SIZE = 8;
    localparam int MAX_GAP = 70;
    localparam int DRAIN_CYCLES = 80;
    localparam int CYCLE_LIMIT = 800_000;
    localparam logic [ADDR_W-1:0] ONES64 = '1;

    typedef struct packed {
        logic fixed;
        rsp_t value;
    } pinned_rsp_t;

    typedef struct packed {
        req_t        req;
        pinned_rsp_t pin;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    req_t request = '0;
    logic busy;
    logic done;
    rsp_t result;

    logic [TABLE_DEPTH-1:0] acl_valid = '0;
    rule_t acl_rules [TABLE_DEPTH];
    rsp_t pending_verdicts [$];
    pinned_rsp_t pinned_verdicts [$];
    int fail_count = 0;
    int cycle_count = 0;
    int idle_pct = 25;

    logic [ADDR_W-1:0] pool_high [POOL_SIZE];
    logic [ADDR_W-1:0] pool_low [POOL_SIZE];
    logic [PORT_W-1:0] pool_port [POOL_SIZE];
    stim_row_t directed_tbl [DIRECTED_ROWS];

    packet_rule_matcher_unit dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .request (request),
        .busy    (busy),
        .done    (done),
        .result  (result)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic rsp_t acl_lookup(req_t txn);
        rsp_t res;
        logic addr_ok;
        res = '0;
        case (txn.cmd)
            CMD_WRITE:
            begin
                if (txn.slot < TABLE_DEPTH)
                begin
                    acl_valid[txn.slot] = 1'b1;
                    acl_rules[txn.slot] = '{txn.addr_high, txn.addr_low, txn.port_number,
                                            txn.is_ipv6, txn.any_address, txn.deny_action};
                end
            end
            CMD_CLEAR:
            begin
                if (txn.slot < TABLE_DEPTH)
                    acl_valid[txn.slot] = 1'b0;
            end
            CMD_CHECK:
            begin
                for (int s = 0; s < TABLE_DEPTH; s++)
                begin
                    if (acl_valid[s] && acl_rules[s].is_ipv6 == txn.is_ipv6)
                    begin
                        if (acl_rules[s].any_address)
                            addr_ok = 1'b1;
                        else if (txn.is_ipv6)
                            addr_ok = acl_rules[s].addr_high == txn.addr_high &&
                                      acl_rules[s].addr_low == txn.addr_low;
                        else
                            addr_ok = acl_rules[s].addr_low[IPV4_W-1:0] ==
                                      txn.addr_low[IPV4_W-1:0];
                        if (addr_ok && (acl_rules[s].port_number == PORT_ANY ||
                                        acl_rules[s].port_number == txn.port_number))
                        begin
                            res.any_hit = 1'b1;
                            if (acl_rules[s].deny_action)
                                res.verdict = 1'b1;
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase
        return res;
    endfunction

    function automatic stim_row_t dir_row(logic [CMD_W-1:0] cmd, int slot,
                                          logic [ADDR_W-1:0] ah, logic [ADDR_W-1:0] al,
                                          logic [PORT_W-1:0] port, int v6, int any,
                                          int deny, int fixed, int verdict,
                                          int hit);
        stim_row_t row;
        row.req = '{cmd, SLOT_W'(slot), ah, al, port, 1'(v6), 1'(any), 1'(deny)};
        row.pin = '{1'(fixed), '{1'(verdict), 1'(hit)}};
        return row;
    endfunction

    task automatic send_txn(input req_t txn, input pinned_rsp_t pin);
        int gap;
        gap = 0;
        if ($urandom_range(99) < idle_pct)
            gap = $urandom_range(MAX_GAP, 1);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pinned_verdicts.push_back(pin);
        start <= 1'b1;
        request <= txn;
        do @(posedge clk); while (busy);
    endtask

    // result check first, then prediction of the transaction taken at this edge
    always @(posedge clk)
    begin
        rsp_t want;
        pinned_rsp_t pin;
        if (rst_n)
        begin
            if (done !== 1'b0)
            begin
                if (pending_verdicts.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: unexpected result verdict=%b any_hit=%b",
                             $time, result.verdict, result.any_hit);
                end
                else
                begin
                    want = pending_verdicts.pop_front();
                    if (result.verdict !== want.verdict)
                    begin
                        fail_count++;
                        $display("%0t: verdict expected %b actual %b",
                                 $time, want.verdict, result.verdict);
                    end
                    if (result.any_hit !== want.any_hit)
                    begin
                        fail_count++;
                        $display("%0t: any_hit expected %b actual %b",
                                 $time, want.any_hit, result.any_hit);
                    end
                end
            end
            if (start && !busy)
            begin
                pin = pinned_verdicts.pop_front();
                want = acl_lookup(request);
                pending_verdicts.push_back(pin.fixed ? pin.value : want);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("packet_rule_matcher_unit regression: fail");
            $finish;
        end
    end

    initial
    begin
        req_t txn;
        int pick;
        int k;
        foreach (pool_high[i])
        begin
            pool_high[i] = {$urandom, $urandom};
            pool_low[i] = {$urandom, $urandom};
            pool_port[i] = PORT_W'($urandom);
        end
        pool_high[0] = '0;
        pool_port[1] = '1;

        directed_tbl = '{
            // empty table, unused command
            dir_row(CMD_CHECK, 0, 64'h0, 64'h0, 16'h0000, 0, 0, 0, 1, 0, 0),
            dir_row(CMD_CHECK, 63, ONES64, ONES64, 16'hFFFF, 1, 1, 1, 1, 0, 0),
            dir_row(CMD_UNUSED, 63, ONES64, ONES64, 16'hFFFF, 1, 1, 1, 1, 0, 0),
            // ipv4 exact rule, upper bits stored but not compared
            dir_row(CMD_WRITE, 0, ONES64, 64'hFFFF_FFFF_0A00_0001, 16'd80, 0, 0, 0, 1, 0, 0),
            dir_row(CMD_CHECK, 7, 64'h0, 64'h0000_0000_0A00_0001, 16'd80, 0, 0, 0, 0, 0, 0),
            dir_row(CMD_CHECK, 7, 64'h0, 64'h0000_0000_0A00_0001, 16'd81, 0, 0, 0, 0, 0, 0),
            dir_row(CMD_CHECK, 7, 64'h0, 64'h0000_0000_0A00_0001, 16'd80, 1, 0, 0, 0, 0, 0),
            // ipv6 exact rule, all 128 bits compared
            dir_row(CMD_WRITE, 63, ONES64, ONES64, 16'hFFFF, 1, 0, 1, 1, 0, 0),
            dir_row(CMD_CHECK, 0, ONES64, ONES64, 16'hFFFF, 1, 0, 0, 0, 0, 0),
            dir_row(CMD_CHECK, 0, 64'h7FFF_FFFF_FFFF_FFFF, ONES64, 16'hFFFF, 1, 0, 0,
                    0, 0, 0),
            dir_row(CMD_CHECK, 0, ONES64, 64'hFFFF_FFFF_FFFF_FFFE, 16'hFFFF, 1, 0, 0,
                    0, 0, 0),
            // wildcard address and port
            dir_row(CMD_WRITE, 5, 64'h1234_5678_9ABC_DEF0, 64'h0FED_CBA9_8765_4321, 16'h0000,
                    0, 1, 1, 1, 0, 0),
            dir_row(CMD_CHECK, 0, 64'h0, 64'h0000_0000_0A00_0001, 16'd80, 0, 0, 0, 0, 0, 0),
            dir_row(CMD_CHECK, 0, 64'h0, 64'h0, 16'h0000, 1, 0, 0, 0, 0, 0),
            // rewrite of a valid slot
            dir_row(CMD_WRITE, 5, 64'h0, 64'h0, 16'd443, 1, 1, 0, 1, 0, 0),
            dir_row(CMD_CHECK, 0, 64'h0, 64'h0000_0000_0A00_0001, 16'd80, 0, 0, 0, 0, 0, 0),
            dir_row(CMD_CHECK, 0, ONES64, ONES64, 16'd443, 1, 0, 0, 0, 0, 0),
            // clears, including one of a slot never written
            dir_row(CMD_CLEAR, 63, 64'h0, 64'h0, 16'h0000, 0, 0, 0, 1, 0, 0),
            dir_row(CMD_CHECK, 0, ONES64, ONES64, 16'hFFFF, 1, 0, 0, 0, 0, 0),
            dir_row(CMD_CLEAR, 0, ONES64, ONES64, 16'hFFFF, 1, 1, 1, 1, 0, 0),
            dir_row(CMD_CLEAR, 5, 64'h0, 64'h0, 16'h0000, 0, 0, 0, 1, 0, 0),
            dir_row(CMD_CLEAR, 17, 64'h0, 64'h0, 16'h0000, 0, 0, 0, 1, 0, 0),
            dir_row(CMD_CHECK, 0, ONES64, ONES64, 16'd443, 1, 0, 0, 1, 0, 0),
            // all-zero ipv4 rule
            dir_row(CMD_WRITE, 32, 64'h0, 64'h0, 16'h0000, 0, 0, 0, 1, 0, 0),
            dir_row(CMD_CHECK, 0, ONES64, 64'hFFFF_FFFF_0000_0000, 16'hFFFF, 0, 0, 0,
                    0, 0, 0)
        };

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_tbl[i])
            send_txn(directed_tbl[i].req, directed_tbl[i].pin);

        for (int n = 0; n < RANDOM_TXNS; n++)
        begin
            if (n == RANDOM_TXNS / 3)
                idle_pct = 45;
            if (n == 2 * RANDOM_TXNS / 3)
                idle_pct = 0;
            pick = $urandom_range(99);
            txn.cmd = pick < 35 ? CMD_WRITE : pick < 50 ? CMD_CLEAR :
                      pick < 96 ? CMD_CHECK : CMD_UNUSED;
            txn.slot = SLOT_W'($urandom_range(TABLE_DEPTH - 1));
            txn.is_ipv6 = 1'($urandom_range(1));
            k = $urandom_range(POOL_SIZE - 1);
            if ($urandom_range(9) < 7)
            begin
                txn.addr_high = pool_high[k];
                txn.addr_low = pool_low[k];
            end
            else
            begin
                txn.addr_high = {$urandom, $urandom};
                txn.addr_low = {$urandom, $urandom};
            end
            // ipv4 ignores everything above the low word
            if (!txn.is_ipv6 && $urandom_range(1))
            begin
                txn.addr_high = {$urandom, $urandom};
                txn.addr_low[ADDR_W-1:IPV4_W] = $urandom;
            end
            pick = $urandom_range(99);
            txn.port_number = pick < 20 ? PORT_ANY : pick < 75 ? pool_port[k] :
                              PORT_W'($urandom);
            txn.any_address = $urandom_range(4) == 0;
            txn.deny_action = 1'($urandom_range(1));
            send_txn(txn, '0);
        end

        start <= 1'b0;
        @(posedge clk);
        while (pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending_verdicts.size() == 0)
            $display("packet_rule_matcher_unit regression: pass");
        else
            $display("packet_rule_matcher_unit regression: fail");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/prm_pkg.sv
rtl/core/prm_rule_mem.sv
rtl/core/prm_match_unit.sv
rtl/core/packet_rule_matcher_unit.sv
sim/tb_packet_rule_matcher_unit.sv
